FILE: sv/grp_pkg.sv
// Shared types and constants for the guillotine rectangle packer.
// Depends on nothing; every other file imports it.
`default_nettype none

package grp_pkg;

  localparam int MAX_FREE  = 64;
  localparam int MAX_SIDE  = 4096;
  localparam int ATLAS_RST = 1024;

  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int POS_W     = SIDE_W - 1;
  localparam int KEY_W     = SIDE_W + 1;
  localparam int IDX_W     = $clog2(MAX_FREE);
  localparam int CNT_W     = $clog2(MAX_FREE + 1);
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic FUNC_RESTART = 1'b0;
  localparam logic FUNC_PLACE   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    STAT_PLACED    = 3'd0,
    STAT_NO_FIT    = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_BAD_SIZE  = 3'd3,
    STAT_RESTARTED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_REMOVE,
    S_INS_START,
    S_INS,
    S_INS_PUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [SIDE_W-1:0] x;
    logic [SIDE_W-1:0] y;
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
  } rect_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    rect_t            data;
  } mem_wr_t;

  typedef struct packed {
    logic fits;
    logic gt;
  } cmp_t;

endpackage

`default_nettype wire

FILE: sv/grp_req_if.sv
// Request channel: func and rectangle size.
// Depends on grp_pkg.
`default_nettype none

interface grp_req_if import grp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [SIDE_W-1:0] rect_width;
  logic [SIDE_W-1:0] rect_height;

  modport source (output valid, func, rect_width, rect_height, input ready);
  modport sink   (input valid, func, rect_width, rect_height, output ready);
endinterface

`default_nettype wire

FILE: sv/grp_res_if.sv
// Result channel: status and placed rectangle.
// Depends on grp_pkg.
`default_nettype none

interface grp_res_if import grp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic [SIDE_W-1:0]   placed_width;
  logic [SIDE_W-1:0]   placed_height;

  modport source (output valid, status, pos_x, pos_y, placed_width, placed_height,
                  input ready);
  modport sink   (input valid, status, pos_x, pos_y, placed_width, placed_height,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/grp_cfg_if.sv
// Configuration write channel: register index and data.
// Depends on grp_pkg.
`default_nettype none

interface grp_cfg_if import grp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIDE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/guillotine_rect_packer_core.sv
// Top level of the guillotine rectangle packer: sequencer, free list, result register.
// Depends on grp_pkg, grp_req_if, grp_res_if, grp_cfg_if, grp_free_mem, grp_key_unit.
//
//   channel | dir | beat payload
//   req     | in  | func, rect_width, rect_height
//   res     | out | status, pos_x, pos_y, placed_width, placed_height
//   cfg     | in  | index, data (atlas_width = 0, atlas_height = 1)
//
// Restart or refused request: the request goes from S_IDLE through S_DONE to the result.
// Placement scans the free list for the first entry that fits, shifts the later
// entries down over it in S_REMOVE, then inserts each leftover piece in half-perimeter
// order, moving up the entries with a larger half-perimeter one entry at a time.
// After reset the S_INIT state writes the whole-atlas entry; req is not ready until then.
// A waiting result does not block the next request; a held result stalls only the
// finish of the following item. cfg is always ready.
`default_nettype none

module guillotine_rect_packer_core import grp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  grp_req_if.sink   req,
  grp_res_if.source res,
  grp_cfg_if.sink   cfg
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  rd_idx, rd_idx_next;
  logic [SIDE_W-1:0] req_w, req_w_next;
  logic [SIDE_W-1:0] req_h, req_h_next;
  rect_t             right_rect, right_rect_next;
  rect_t             bottom_rect, bottom_rect_next;
  logic              right_pend, right_pend_next;
  logic              bottom_pend, bottom_pend_next;
  rect_t             ins, ins_next;
  logic [KEY_W-1:0]  ins_key, ins_key_next;
  status_t           status_r, status_r_next;
  logic [POS_W-1:0]  px, px_next;
  logic [POS_W-1:0]  py, py_next;
  logic [SIDE_W-1:0] pw, pw_next;
  logic [SIDE_W-1:0] ph, ph_next;
  logic [SIDE_W-1:0] atlas_w, atlas_h;

  logic                res_valid, res_valid_next;
  logic [STATUS_W-1:0] res_status;
  logic [POS_W-1:0]    res_x, res_y;
  logic [SIDE_W-1:0]   res_w, res_h;
  logic                res_load;

  mem_wr_t          wr;
  logic [IDX_W-1:0] raddr;
  rect_t            rdata;
  cmp_t             cmp;
  rect_t            restart_rect;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end
    return r;
  endfunction

  assign restart_rect = '{x: '0, y: '0, w: clamp_side(atlas_w), h: clamp_side(atlas_h)};

  grp_free_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  grp_key_unit u_key (
    .ent     (rdata),
    .need_w  (req_w),
    .need_h  (req_h),
    .ref_key (ins_key),
    .cmp     (cmp)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_w <= SIDE_W'(ATLAS_RST);
      atlas_h <= SIDE_W'(ATLAS_RST);
    end else if (cfg.valid) begin
      if (cfg.index == CFG_ATLAS_WIDTH) begin
        atlas_w <= cfg.data;
      end else if (cfg.index == CFG_ATLAS_HEIGHT) begin
        atlas_h <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      count       <= CNT_W'(1);
      right_pend  <= 1'b0;
      bottom_pend <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      right_pend  <= right_pend_next;
      bottom_pend <= bottom_pend_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx      <= rd_idx_next;
    req_w       <= req_w_next;
    req_h       <= req_h_next;
    right_rect  <= right_rect_next;
    bottom_rect <= bottom_rect_next;
    ins         <= ins_next;
    ins_key     <= ins_key_next;
    status_r    <= status_r_next;
    px          <= px_next;
    py          <= py_next;
    pw          <= pw_next;
    ph          <= ph_next;
    if (res_load) begin
      res_status <= status_r;
      res_x      <= px;
      res_y      <= py;
      res_w      <= pw;
      res_h      <= ph;
    end
  end

  assign res.valid         = res_valid;
  assign res.status        = res_status;
  assign res.pos_x         = res_x;
  assign res.pos_y         = res_y;
  assign res.placed_width  = res_w;
  assign res.placed_height = res_h;

  always_comb begin
    rect_t            piece;
    logic             take;
    logic [1:0]       pieces;
    logic [CNT_W:0]   need;

    state_next       = state;
    count_next       = count;
    rd_idx_next      = rd_idx;
    req_w_next       = req_w;
    req_h_next       = req_h;
    right_rect_next  = right_rect;
    bottom_rect_next = bottom_rect;
    right_pend_next  = right_pend;
    bottom_pend_next = bottom_pend;
    ins_next         = ins;
    ins_key_next     = ins_key;
    status_r_next    = status_r;
    px_next          = px;
    py_next          = py;
    pw_next          = pw;
    ph_next          = ph;
    res_valid_next   = res_valid && !res.ready;
    res_load         = 1'b0;
    req.ready        = (state == S_IDLE);
    raddr            = rd_idx;
    wr               = '0;
    piece            = right_rect;
    take             = 1'b0;
    pieces           = {1'b0, rdata.w > req_w} + {1'b0, rdata.h > req_h};
    need             = {1'b0, count} + (CNT_W + 1)'(pieces);

    unique case (state)
      S_INIT: begin
        wr.en      = 1'b1;
        wr.addr    = '0;
        wr.data    = restart_rect;
        count_next = CNT_W'(1);
        state_next = S_IDLE;
      end

      S_IDLE: begin
        if (req.valid) begin
          req_w_next = req.rect_width;
          req_h_next = req.rect_height;
          px_next    = '0;
          py_next    = '0;
          pw_next    = '0;
          ph_next    = '0;
          if (req.func == FUNC_RESTART) begin
            wr.en         = 1'b1;
            wr.addr       = '0;
            wr.data       = restart_rect;
            count_next    = CNT_W'(1);
            status_r_next = STAT_RESTARTED;
            state_next    = S_DONE;
          end else if (req.rect_width == '0 || req.rect_height == '0 ||
                       req.rect_width > SIDE_W'(MAX_SIDE) ||
                       req.rect_height > SIDE_W'(MAX_SIDE)) begin
            status_r_next = STAT_BAD_SIZE;
            state_next    = S_DONE;
          end else if (count == '0) begin
            status_r_next = STAT_NO_FIT;
            state_next    = S_DONE;
          end else begin
            raddr       = '0;
            rd_idx_next = '0;
            state_next  = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (cmp.fits) begin
          if (need > (CNT_W + 1)'(MAX_FREE + 1)) begin
            status_r_next = STAT_FULL;
            state_next    = S_DONE;
          end else begin
            right_rect_next  = '{x: rdata.x + req_w, y: rdata.y,
                                 w: rdata.w - req_w, h: req_h};
            bottom_rect_next = '{x: rdata.x, y: rdata.y + req_h,
                                 w: rdata.w, h: rdata.h - req_h};
            right_pend_next  = rdata.w > req_w;
            bottom_pend_next = rdata.h > req_h;
            status_r_next    = STAT_PLACED;
            px_next          = rdata.x[POS_W-1:0];
            py_next          = rdata.y[POS_W-1:0];
            pw_next          = req_w;
            ph_next          = req_h;
            if (CNT_W'(rd_idx) + CNT_W'(1) < count) begin
              raddr       = rd_idx + IDX_W'(1);
              rd_idx_next = rd_idx + IDX_W'(1);
              state_next  = S_REMOVE;
            end else begin
              count_next = count - CNT_W'(1);
              state_next = S_INS_START;
            end
          end
        end else if (CNT_W'(rd_idx) + CNT_W'(1) == count) begin
          status_r_next = STAT_NO_FIT;
          state_next    = S_DONE;
        end else begin
          raddr       = rd_idx + IDX_W'(1);
          rd_idx_next = rd_idx + IDX_W'(1);
        end
      end

      S_REMOVE: begin
        wr.en   = 1'b1;
        wr.addr = rd_idx - IDX_W'(1);
        wr.data = rdata;
        if (CNT_W'(rd_idx) + CNT_W'(1) < count) begin
          raddr       = rd_idx + IDX_W'(1);
          rd_idx_next = rd_idx + IDX_W'(1);
        end else begin
          count_next = count - CNT_W'(1);
          state_next = S_INS_START;
        end
      end

      S_INS_START: begin
        if (right_pend) begin
          piece           = right_rect;
          take            = 1'b1;
          right_pend_next = 1'b0;
        end else if (bottom_pend) begin
          piece            = bottom_rect;
          take             = 1'b1;
          bottom_pend_next = 1'b0;
        end else begin
          state_next = S_DONE;
        end
        if (take) begin
          ins_next     = piece;
          ins_key_next = KEY_W'(piece.w) + KEY_W'(piece.h);
          if (count == '0) begin
            wr.en      = 1'b1;
            wr.addr    = '0;
            wr.data    = piece;
            count_next = count + CNT_W'(1);
          end else begin
            raddr       = IDX_W'(count - CNT_W'(1));
            rd_idx_next = IDX_W'(count - CNT_W'(1));
            state_next  = S_INS;
          end
        end
      end

      S_INS: begin
        wr.en   = 1'b1;
        wr.addr = rd_idx + IDX_W'(1);
        if (cmp.gt) begin
          wr.data = rdata;
          if (rd_idx == '0) begin
            state_next = S_INS_PUT;
          end else begin
            raddr       = rd_idx - IDX_W'(1);
            rd_idx_next = rd_idx - IDX_W'(1);
          end
        end else begin
          wr.data    = ins;
          count_next = count + CNT_W'(1);
          state_next = S_INS_START;
        end
      end

      S_INS_PUT: begin
        wr.en      = 1'b1;
        wr.addr    = '0;
        wr.data    = ins;
        count_next = count + CNT_W'(1);
        state_next = S_INS_START;
      end

      S_DONE: begin
        if (!res_valid || res.ready) begin
          res_load       = 1'b1;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/grp_free_mem.sv
// Free rectangle store: one write port, one read port with registered data.
// Depends on grp_pkg.
`default_nettype none

module grp_free_mem import grp_pkg::*; (
  input  logic             clk,
  input  mem_wr_t          wr,
  input  logic [IDX_W-1:0] raddr,
  output rect_t            rdata
);

  rect_t mem [MAX_FREE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/grp_key_unit.sv
// Shared compare unit: fit test and half-perimeter compare of one entry.
// Depends on grp_pkg.
`default_nettype none

module grp_key_unit import grp_pkg::*; (
  input  rect_t             ent,
  input  logic [SIDE_W-1:0] need_w,
  input  logic [SIDE_W-1:0] need_h,
  input  logic [KEY_W-1:0]  ref_key,
  output cmp_t              cmp
);

  logic [KEY_W-1:0] ent_key;

  assign ent_key  = KEY_W'(ent.w) + KEY_W'(ent.h);
  assign cmp.fits = (ent.w >= need_w) && (ent.h >= need_h);
  assign cmp.gt   = ent_key > ref_key;

endmodule

`default_nettype wire
